// File: hw/rtl/bounded_mailbox_with_overflow_policy_unit_assert.svh
// Assertion macros shared by the mailbox RTL.
// Both macros expect signals named clk and rst_n in the enclosing module.
`ifndef BOUNDED_MAILBOX_WITH_OVERFLOW_POLICY_UNIT_ASSERT_SVH
`define BOUNDED_MAILBOX_WITH_OVERFLOW_POLICY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMBOX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMBOX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bmbox_pkg.sv
package bmbox_pkg;

  localparam int unsigned ID_W       = 32;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned MSG_CNT_W  = 5;
  localparam int unsigned BYTES_W    = 20;
  localparam int unsigned COUNTER_W  = 32;
  localparam int unsigned POLICY_W   = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CMD_W      = 1;

  localparam int unsigned SLOT_W     = ID_W + HANDLE_W + SIZE_W;
  localparam int unsigned IN_TDATA_W = ((SLOT_W + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = SLOT_W + MSG_CNT_W + BYTES_W + 2 * COUNTER_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = BYTES_W;

  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [POLICY_W-1:0]    policy_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CMD_W-1:0]       cmd_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_BLOCK = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

  localparam policy_t POL_DROP_NEW = 2'd0;
  localparam policy_t POL_DROP_OLD = 2'd1;
  localparam policy_t POL_BLOCK    = 2'd2;
  localparam policy_t POL_CRASH    = 2'd3;

  localparam cmd_t CMD_PUSH = 1'b0;
  localparam cmd_t CMD_POP  = 1'b1;

  localparam cfg_index_t CFG_MAX_MESSAGES = 2'd0;
  localparam cfg_index_t CFG_MAX_BYTES    = 2'd1;
  localparam cfg_index_t CFG_POLICY       = 2'd2;

endpackage

// File: hw/rtl/bmbox_ram.sv
module bmbox_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/bounded_mailbox_with_overflow_policy_unit.sv
// A pop, or a push refused at the depth or count check, passes S_CHECK and then S_DONE, which
// loads its result into the output register when that is free; a push that reaches the byte
// check also passes S_BYTE. An eviction on the count limit adds S_EVICT; each on the byte limit
// adds S_EVICT then S_BYTE, as the registered RAM read must follow the moved read pointer.
// A new request is accepted in the cycle after a result is loaded, while that result may wait.
// Reset (rst_n low, synchronous) empties the queue, clears the counters and the limits.
module bounded_mailbox_with_overflow_policy_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: sender_id, payload_handle, size.
  input  logic [bmbox_pkg::IN_TDATA_W-1:0] in_tdata,
  // Fields from bit 0: cmd.
  input  logic [bmbox_pkg::CMD_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: out_sender, out_payload, out_size, msg_count, bytes_in_use,
  // drops_total, received_total, then zero fill.
  output logic [bmbox_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Fields from bit 0: status.
  output logic [bmbox_pkg::STATUS_W-1:0]   out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmbox_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bmbox_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bmbox_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (OCC_W > MSG_CNT_W) ? OCC_W : MSG_CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BYTE,
    S_EVICT,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [OCC_W-1:0]       occ_r, occ_nxt;
  logic [BYTES_W-1:0]     bytes_r, bytes_nxt;
  logic [COUNTER_W-1:0]   drops_r, drops_nxt;
  logic [COUNTER_W-1:0]   rcv_r, rcv_nxt;
  logic [MSG_CNT_W-1:0]   max_messages_r, max_messages_nxt;
  logic [BYTES_W-1:0]     max_bytes_r, max_bytes_nxt;
  policy_t                policy_r, policy_nxt;
  logic                   out_valid_r, out_valid_nxt;

  cmd_t                   cmd_r, cmd_nxt;
  logic [ID_W-1:0]        itm_sender_r, itm_sender_nxt;
  logic [HANDLE_W-1:0]    itm_payload_r, itm_payload_nxt;
  logic [SIZE_W-1:0]      itm_size_r, itm_size_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [ID_W-1:0]        res_sender_r, res_sender_nxt;
  logic [HANDLE_W-1:0]    res_payload_r, res_payload_nxt;
  logic [SIZE_W-1:0]      res_size_r, res_size_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  status_t                out_tuser_r, out_tuser_nxt;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_rdata;
  logic [ID_W-1:0]        head_sender;
  logic [HANDLE_W-1:0]    head_payload;
  logic [SIZE_W-1:0]      head_size;

  logic                   out_free;
  logic                   depth_full;
  logic                   count_hit;
  logic [BYTES_W:0]       byte_sum;
  logic                   byte_over;
  logic [BYTES_W-1:0]     bytes_less_head;
  logic [MSG_CNT_W-1:0]   msg_count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  bmbox_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr_r),
    .wdata({itm_size_r, itm_payload_r, itm_sender_r}),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  assign head_sender  = ram_rdata[ID_W-1:0];
  assign head_payload = ram_rdata[ID_W+HANDLE_W-1:ID_W];
  assign head_size    = ram_rdata[SLOT_W-1:ID_W+HANDLE_W];

  assign out_free   = !out_valid_r || out_tready;
  assign depth_full = (occ_r >= OCC_W'(QUEUE_DEPTH));
  assign count_hit  = (max_messages_r != '0) && (CMP_W'(occ_r) >= CMP_W'(max_messages_r));
  assign byte_sum   = {1'b0, bytes_r} + (BYTES_W + 1)'(itm_size_r);
  assign byte_over  = (max_bytes_r != '0) && (byte_sum > {1'b0, max_bytes_r});
  assign bytes_less_head = (bytes_r >= BYTES_W'(head_size)) ? bytes_r - BYTES_W'(head_size)
                                                            : '0;
  assign msg_count  = MSG_CNT_W'(CMP_W'(occ_r));

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    state_nxt        = state_r;
    rd_ptr_nxt       = rd_ptr_r;
    wr_ptr_nxt       = wr_ptr_r;
    occ_nxt          = occ_r;
    bytes_nxt        = bytes_r;
    drops_nxt        = drops_r;
    rcv_nxt          = rcv_r;
    max_messages_nxt = max_messages_r;
    max_bytes_nxt    = max_bytes_r;
    policy_nxt       = policy_r;
    out_valid_nxt    = out_valid_r;
    cmd_nxt          = cmd_r;
    itm_sender_nxt   = itm_sender_r;
    itm_payload_nxt  = itm_payload_r;
    itm_size_nxt     = itm_size_r;
    res_status_nxt   = res_status_r;
    res_sender_nxt   = res_sender_r;
    res_payload_nxt  = res_payload_r;
    res_size_nxt     = res_size_r;
    out_tdata_nxt    = out_tdata_r;
    out_tuser_nxt    = out_tuser_r;
    ram_we           = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_MESSAGES: max_messages_nxt = cfg_data[MSG_CNT_W-1:0];
        CFG_MAX_BYTES:    max_bytes_nxt    = cfg_data[BYTES_W-1:0];
        CFG_POLICY:       policy_nxt       = cfg_data[POLICY_W-1:0];
        default:          ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt         = in_tuser;
          itm_sender_nxt  = in_tdata[ID_W-1:0];
          itm_payload_nxt = in_tdata[ID_W+HANDLE_W-1:ID_W];
          itm_size_nxt    = in_tdata[SLOT_W-1:ID_W+HANDLE_W];
          res_status_nxt  = ST_OK;
          res_sender_nxt  = '0;
          res_payload_nxt = '0;
          res_size_nxt    = '0;
          state_nxt       = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_POP) begin
          if (occ_r == '0) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            res_sender_nxt  = head_sender;
            res_payload_nxt = head_payload;
            res_size_nxt    = head_size;
            rd_ptr_nxt      = ptr_inc(rd_ptr_r);
            occ_nxt         = occ_r - 1'b1;
            bytes_nxt       = bytes_less_head;
          end
        end else if (depth_full) begin
          res_status_nxt = ST_FULL;
        end else if (count_hit) begin
          unique case (policy_r)
            POL_DROP_NEW: begin
              drops_nxt      = drops_r + 1'b1;
              res_status_nxt = ST_FULL;
            end
            POL_DROP_OLD: begin
              if (occ_r == '0) begin
                res_status_nxt = ST_FULL;
              end else begin
                state_nxt = S_EVICT;
              end
            end
            POL_BLOCK: res_status_nxt = ST_BLOCK;
            default:   res_status_nxt = ST_FULL;
          endcase
        end else begin
          state_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        state_nxt = S_DONE;
        if (byte_over && (policy_r == POL_DROP_OLD) && (occ_r != '0)) begin
          state_nxt = S_EVICT;
        end else if (byte_over && (policy_r == POL_DROP_NEW)) begin
          drops_nxt      = drops_r + 1'b1;
          res_status_nxt = ST_FULL;
        end else if (byte_over && (policy_r == POL_BLOCK)) begin
          res_status_nxt = ST_BLOCK;
        end else if (byte_over && (policy_r == POL_CRASH)) begin
          res_status_nxt = ST_FULL;
        end else begin
          ram_we     = 1'b1;
          wr_ptr_nxt = ptr_inc(wr_ptr_r);
          occ_nxt    = occ_r + 1'b1;
          bytes_nxt  = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
          rcv_nxt    = rcv_r + 1'b1;
        end
      end
      S_EVICT: begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
        occ_nxt    = occ_r - 1'b1;
        bytes_nxt  = bytes_less_head;
        drops_nxt  = drops_r + 1'b1;
        state_nxt  = S_BYTE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = res_status_r;
          out_tdata_nxt = OUT_TDATA_W'({rcv_r, drops_r, bytes_r, msg_count,
                                        res_size_r, res_payload_r, res_sender_r});
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      rd_ptr_r       <= '0;
      wr_ptr_r       <= '0;
      occ_r          <= '0;
      bytes_r        <= '0;
      drops_r        <= '0;
      rcv_r          <= '0;
      max_messages_r <= '0;
      max_bytes_r    <= '0;
      policy_r       <= POL_DROP_NEW;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
      wr_ptr_r       <= wr_ptr_nxt;
      occ_r          <= occ_nxt;
      bytes_r        <= bytes_nxt;
      drops_r        <= drops_nxt;
      rcv_r          <= rcv_nxt;
      max_messages_r <= max_messages_nxt;
      max_bytes_r    <= max_bytes_nxt;
      policy_r       <= policy_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    itm_sender_r  <= itm_sender_nxt;
    itm_payload_r <= itm_payload_nxt;
    itm_size_r    <= itm_size_nxt;
    res_status_r  <= res_status_nxt;
    res_sender_r  <= res_sender_nxt;
    res_payload_r <= res_payload_nxt;
    res_size_r    <= res_size_nxt;
    out_tdata_r   <= out_tdata_nxt;
    out_tuser_r   <= out_tuser_nxt;
  end

`include "bounded_mailbox_with_overflow_policy_unit_assert.svh"

  `BMBOX_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= OCC_W'(QUEUE_DEPTH), "occupancy above depth")
  `BMBOX_ASSERT_NOW(a_empty_ptrs, occ_r == '0, rd_ptr_r == wr_ptr_r, "split pointers")
  `BMBOX_ASSERT_NOW(a_evict_nonempty, state_r == S_EVICT, occ_r != '0, "empty eviction")
  `BMBOX_ASSERT_NEXT(a_evict_drop, state_r == S_EVICT, drops_r == $past(drops_r) + 1'b1, "no drop")
  `BMBOX_ASSERT_NEXT(a_done_out, state_r == S_DONE && out_free, out_valid_r, "result lost")

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmbox_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam logic [BYTES_W-1:0] BYTES_FULL = '1;

  typedef struct {
    status_t                status;
    logic [ID_W-1:0]        sender;
    logic [HANDLE_W-1:0]    payload;
    logic [SIZE_W-1:0]      size;
    logic [MSG_CNT_W-1:0]   count;
    logic [BYTES_W-1:0]     bytes;
    logic [COUNTER_W-1:0]   drops;
    logic [COUNTER_W-1:0]   received;
  } reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  cmd_t                   in_tuser = CMD_PUSH;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  status_t                out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_index_t             cfg_index = CFG_MAX_MESSAGES;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic [ID_W-1:0]      box_sender [DEPTH];
  logic [HANDLE_W-1:0]  box_payload [DEPTH];
  logic [SIZE_W-1:0]    box_size [DEPTH];
  int unsigned          box_head = 0;
  int unsigned          box_tail = 0;
  int unsigned          box_fill = 0;
  int unsigned          box_bytes = 0;
  logic [COUNTER_W-1:0] box_drops = '0;
  logic [COUNTER_W-1:0] box_received = '0;
  int unsigned          limit_count = 0;
  int unsigned          limit_bytes = 0;
  policy_t              limit_policy = POL_DROP_NEW;

  reply_t      replies_due[$];
  int unsigned failures = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned holdoff_cycles = 0;

  bounded_mailbox_with_overflow_policy_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void remove_oldest(output logic [ID_W-1:0] snd,
                                        output logic [HANDLE_W-1:0] pay,
                                        output logic [SIZE_W-1:0] sz);
    snd = box_sender[box_head];
    pay = box_payload[box_head];
    sz = box_size[box_head];
    box_head = (box_head + 1) % DEPTH;
    box_fill--;
    box_bytes = (box_bytes >= sz) ? box_bytes - sz : 0;
  endfunction

  function automatic bit evict_oldest();
    logic [ID_W-1:0]     snd;
    logic [HANDLE_W-1:0] pay;
    logic [SIZE_W-1:0]   sz;
    if (box_fill == 0) return 1'b0;
    remove_oldest(snd, pay, sz);
    box_drops++;
    return 1'b1;
  endfunction

  function automatic status_t enqueue_message(logic [ID_W-1:0] snd,
                                              logic [HANDLE_W-1:0] pay,
                                              logic [SIZE_W-1:0] sz);
    if (box_fill >= DEPTH) return ST_FULL;
    if (limit_count != 0 && box_fill >= limit_count) begin
      case (limit_policy)
        POL_DROP_NEW: begin
          box_drops++;
          return ST_FULL;
        end
        POL_DROP_OLD: begin
          if (!evict_oldest()) return ST_FULL;
        end
        POL_BLOCK: return ST_BLOCK;
        default: return ST_FULL;
      endcase
    end
    if (limit_bytes != 0 && box_bytes + sz > limit_bytes) begin
      case (limit_policy)
        POL_DROP_NEW: begin
          box_drops++;
          return ST_FULL;
        end
        POL_DROP_OLD: begin
          // The new message goes in even when it alone exceeds the limit.
          while (box_bytes + sz > limit_bytes) begin
            if (!evict_oldest()) break;
          end
        end
        POL_BLOCK: return ST_BLOCK;
        default: return ST_FULL;
      endcase
    end
    box_sender[box_tail] = snd;
    box_payload[box_tail] = pay;
    box_size[box_tail] = sz;
    box_tail = (box_tail + 1) % DEPTH;
    box_fill++;
    box_bytes = (box_bytes + sz > BYTES_FULL) ? BYTES_FULL : box_bytes + sz;
    box_received++;
    return ST_OK;
  endfunction

  function automatic reply_t predict_reply(cmd_t cmd, logic [ID_W-1:0] snd,
                                           logic [HANDLE_W-1:0] pay,
                                           logic [SIZE_W-1:0] sz);
    reply_t r;
    r.sender = '0;
    r.payload = '0;
    r.size = '0;
    if (cmd == CMD_PUSH) begin
      r.status = enqueue_message(snd, pay, sz);
    end else if (box_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      remove_oldest(r.sender, r.payload, r.size);
      r.status = ST_OK;
    end
    r.count = MSG_CNT_W'(box_fill);
    r.bytes = BYTES_W'(box_bytes);
    r.drops = box_drops;
    r.received = box_received;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $error("A reply arrived with no request outstanding.");
        failures++;
      end else begin
        want = replies_due.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("out_sender", want.sender, out_tdata[31:0]);
        check_field("out_payload", want.payload, out_tdata[63:32]);
        check_field("out_size", want.size, out_tdata[79:64]);
        check_field("msg_count", want.count, out_tdata[84:80]);
        check_field("bytes_in_use", want.bytes, out_tdata[104:85]);
        check_field("drops_total", want.drops, out_tdata[136:105]);
        check_field("received_total", want.received, out_tdata[168:137]);
      end
    end
  end

  always @(negedge clk) begin
    if (holdoff_cycles != 0) begin
      out_tready <= 1'b0;
      holdoff_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic send_request(cmd_t cmd, logic [ID_W-1:0] snd, logic [HANDLE_W-1:0] pay,
                              logic [SIZE_W-1:0] sz);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {sz, pay, snd};
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    replies_due.push_back(predict_reply(cmd, snd, pay, sz));
  endtask

  task automatic send_random(int unsigned push_pct);
    logic [SIZE_W-1:0]   sz;
    logic [ID_W-1:0]     snd;
    logic [HANDLE_W-1:0] pay;
    case ($urandom_range(5))
      0: sz = '0;
      1: sz = '1;
      2, 3: sz = SIZE_W'($urandom_range(255));
      default: sz = SIZE_W'($urandom());
    endcase
    snd = $urandom();
    pay = $urandom();
    if ($urandom_range(15) == 0) snd = '1;
    if ($urandom_range(15) == 0) pay = '0;
    send_request(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, snd, pay, sz);
  endtask

  task automatic wait_all_replies();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_MESSAGES: limit_count = value[MSG_CNT_W-1:0];
      CFG_MAX_BYTES: limit_bytes = value;
      CFG_POLICY: limit_policy = value[POLICY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(int unsigned count, int unsigned bytes, policy_t policy);
    write_register(CFG_MAX_MESSAGES, CFG_DATA_W'(count));
    write_register(CFG_MAX_BYTES, CFG_DATA_W'(bytes));
    write_register(CFG_POLICY, CFG_DATA_W'(policy));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct = 75;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 75;
      end
      default: begin
        sender_idle_pct = 22;
        receiver_stall_pct = 22;
      end
    endcase
  endtask

  task automatic test_field_extremes();
    send_request(CMD_POP, '0, '0, '0);
    send_request(CMD_PUSH, '0, '0, '0);
    send_request(CMD_PUSH, '1, '1, '1);
    send_request(CMD_POP, '1, '1, '1);
    send_request(CMD_POP, '0, '0, '0);
    send_request(CMD_POP, '0, '0, '0);
    wait_all_replies();
  endtask

  task automatic test_hardware_full();
    for (int i = 0; i <= DEPTH; i++) begin
      send_request(CMD_PUSH, $urandom(), $urandom(), SIZE_W'(i * 4099));
    end
    wait_all_replies();
  endtask

  task automatic test_drop_oldest();
    set_limits(3, 0, POL_DROP_OLD);
    send_request(CMD_POP, '0, '0, '0);
    send_request(CMD_PUSH, $urandom(), $urandom(), SIZE_W'($urandom()));
    wait_all_replies();
    set_limits(0, 1000, POL_DROP_OLD);
    send_request(CMD_PUSH, $urandom(), $urandom(), '1);
    send_request(CMD_PUSH, $urandom(), $urandom(), SIZE_W'(900));
    wait_all_replies();
  endtask

  task automatic test_backpressure();
    set_limits(0, 0, POL_DROP_NEW);
    set_idling(0);
    @(posedge clk);
    holdoff_cycles = 300;
    repeat (40) send_random(60);
    wait_all_replies();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 16; phase++) begin
      int unsigned count_limit;
      int unsigned byte_limit;
      case ((phase + phase / 4) % 4)
        0: count_limit = 0;
        1: count_limit = 1;
        2: count_limit = DEPTH;
        default: count_limit = $urandom_range(2, DEPTH - 1);
      endcase
      case (phase % 5)
        0: byte_limit = 0;
        1: byte_limit = BYTES_FULL;
        2: byte_limit = 1;
        3: byte_limit = $urandom_range(1024, 150000);
        default: byte_limit = $urandom_range(BYTES_FULL);
      endcase
      set_limits(count_limit, byte_limit, policy_t'(phase / 4));
      set_idling(phase % 4);
      repeat (100) send_random($urandom_range(45, 75));
      wait_all_replies();
    end
  endtask

  initial begin
    set_idling(0);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_hardware_full();
    test_drop_oldest();
    test_backpressure();
    test_random_traffic();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: bounded_mailbox_with_overflow_policy_unit.f
+incdir+hw/rtl
hw/rtl/bmbox_pkg.sv
hw/rtl/bmbox_ram.sv
hw/rtl/bounded_mailbox_with_overflow_policy_unit.sv
dv/testbench.sv
